[sv/lfd_pkg.sv]
// shared types, constants and the fnv-1a step for the line flag table
`timescale 1ns / 1ps

package lfd_pkg;

  // fixed field widths
  localparam int CountW = 13;
  localparam int IndexW = 12;
  localparam int FlagW  = 8;
  localparam int DigW   = 32;
  // byte count of one table walk: ceil(count / 8), up to 1024 bytes
  localparam int NbytesW = CountW - 2;

  // apb register map
  localparam int ApbAw = 3;
  localparam logic REG_IDX_LINE_COUNT = 1'b0;

  // fnv-1a 32-bit constants
  localparam logic [DigW-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [DigW-1:0] FNV_PRIME = 32'd16777619;

  typedef enum logic [1:0] {
    OP_CLEAR      = 2'd0,
    OP_GET        = 2'd1,
    OP_SET_OPEN   = 2'd2,
    OP_SET_LOCKED = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_READY = 2'd1,
    STAT_BAD_ARG   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CLR,
    ST_HASH,
    ST_RESP
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [IndexW-1:0]  line_index;
    logic [FlagW-1:0]   flag_value;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic               open_flag;
    logic               locked_flag;
    logic [CountW-1:0]  open_total;
    logic [CountW-1:0]  locked_total;
    logic [DigW-1:0]    state_digest;
  } result_t;

  // one fnv-1a byte step
  function automatic logic [DigW-1:0] fnv_step(logic [DigW-1:0] h, logic [7:0] b);
    logic [DigW-1:0] x;
    x = h ^ {24'd0, b};
    return x * FNV_PRIME;
  endfunction

endpackage

[sv/lfd_ram.sv]
// byte-wide single write port ram with one registered read port
`timescale 1ns / 1ps

module lfd_ram #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[sv/lfd_engine.sv]
// op sequencer: table read-modify-write, clearing sweep and digest walk
`timescale 1ns / 1ps

module lfd_engine #(
  parameter int LINES_MAX = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lfd_pkg::item_t        item_i,
  input  logic [lfd_pkg::CountW-1:0] line_count_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output lfd_pkg::result_t      res_o
);

  import lfd_pkg::*;

  localparam int TableBytes = (LINES_MAX + 7) / 8;
  localparam int AW = (TableBytes > 1) ? $clog2(TableBytes) : 1;

  state_e               state_q, state_d;

  // captured item
  op_e                  op_q;
  logic [IndexW-1:0]    idx_q;
  logic [FlagW-1:0]     fv_q;

  // block state
  logic [CountW-1:0]    open_tally_q, locked_tally_q, active_q;
  logic [DigW-1:0]      digest_q;
  logic                 ready_q;
  logic [NbytesW-1:0]   nbytes_q;

  // result registers
  status_e              status_q;
  logic                 of_q, lf_q;

  // walk control
  logic [AW-1:0]        addr_q;
  logic                 pass_q, issue_done_q, rd_vld_q, rd_pass_q;

  // ram ports
  logic                 we_open, we_lock;
  logic [AW-1:0]        waddr, raddr;
  logic [7:0]           wdata, open_rdata, lock_rdata;

  // decode of the incoming item
  logic                 accept;
  logic                 clr_bad, arg_bad;
  logic [NbytesW-1:0]   new_nbytes;
  logic                 last_addr;

  // read-modify-write of the addressed byte
  logic [2:0]           bsel;
  logic [7:0]           bmask;
  logic                 open_bit, lock_bit;
  logic                 chg_open, chg_lock;
  logic [7:0]           open_mod, lock_mod;
  logic [7:0]           hash_byte;

  assign accept     = in_valid_i && in_ready_o;
  assign clr_bad    = (line_count_i == '0) || (32'(line_count_i) > 32'(LINES_MAX));
  assign arg_bad    = ({1'b0, item_i.line_index} >= active_q) ||
                      ((item_i.op != OP_GET) && (item_i.flag_value > 8'd1));
  assign new_nbytes = NbytesW'((14'(line_count_i) + 14'd7) >> 3);
  assign last_addr  = 16'(addr_q) == 16'(nbytes_q - NbytesW'(1));

  assign bsel      = idx_q[2:0];
  assign bmask     = 8'd1 << bsel;
  assign open_bit  = open_rdata[bsel];
  assign lock_bit  = lock_rdata[bsel];
  assign chg_open  = (op_q == OP_SET_OPEN) && (open_bit != fv_q[0]);
  assign chg_lock  = (op_q == OP_SET_LOCKED) && (lock_bit != fv_q[0]);
  assign open_mod  = (open_rdata & ~bmask) | (fv_q[0] ? bmask : 8'd0);
  assign lock_mod  = (lock_rdata & ~bmask) | (fv_q[0] ? bmask : 8'd0);
  assign hash_byte = rd_pass_q ? lock_rdata : open_rdata;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (item_i.op == OP_CLEAR) begin
            state_d = clr_bad ? ST_RESP : ST_CLR;
          end else if (!ready_q || arg_bad) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: state_d = (chg_open || chg_lock) ? ST_HASH : ST_RESP;
      ST_CLR:  state_d = last_addr ? ST_HASH : ST_CLR;
      ST_HASH: state_d = (issue_done_q && !rd_vld_q) ? ST_RESP : ST_HASH;
      ST_RESP: state_d = res_ready_i ? ST_IDLE : ST_RESP;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and ram controls
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    we_open     = 1'b0;
    we_lock     = 1'b0;
    waddr       = AW'(idx_q[IndexW-1:3]);
    wdata       = 8'd0;
    raddr       = addr_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        raddr      = AW'(item_i.line_index[IndexW-1:3]);
      end
      ST_READ: begin
        we_open = chg_open;
        we_lock = chg_lock;
        wdata   = chg_open ? open_mod : lock_mod;
      end
      ST_CLR: begin
        we_open = 1'b1;
        we_lock = 1'b1;
        waddr   = addr_q;
      end
      ST_RESP: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  // result assembly
  always_comb begin
    res_o.status       = status_q;
    res_o.open_flag    = of_q;
    res_o.locked_flag  = lf_q;
    res_o.open_total   = open_tally_q;
    res_o.locked_total = locked_tally_q;
    res_o.state_digest = ready_q ? digest_q : '0;
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= item_i.op;
      idx_q <= item_i.line_index;
      fv_q  <= item_i.flag_value;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      open_tally_q   <= '0;
      locked_tally_q <= '0;
      active_q       <= '0;
      digest_q       <= '0;
      ready_q        <= 1'b0;
      nbytes_q       <= '0;
      status_q       <= STAT_OK;
      of_q           <= 1'b0;
      lf_q           <= 1'b0;
      addr_q         <= '0;
      pass_q         <= 1'b0;
      issue_done_q   <= 1'b0;
      rd_vld_q       <= 1'b0;
      rd_pass_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            of_q     <= 1'b0;
            lf_q     <= 1'b0;
            addr_q   <= '0;
            status_q <= STAT_OK;
            if (item_i.op == OP_CLEAR) begin
              if (clr_bad) begin
                status_q <= STAT_BAD_ARG;
              end else begin
                active_q       <= line_count_i;
                nbytes_q       <= new_nbytes;
                ready_q        <= 1'b1;
                open_tally_q   <= '0;
                locked_tally_q <= '0;
              end
            end else if (!ready_q) begin
              status_q <= STAT_NOT_READY;
            end else if (arg_bad) begin
              status_q <= STAT_BAD_ARG;
            end
          end
        end
        ST_READ: begin
          of_q <= (op_q == OP_SET_OPEN) ? fv_q[0] : open_bit;
          lf_q <= (op_q == OP_SET_LOCKED) ? fv_q[0] : lock_bit;
          if (chg_open) begin
            open_tally_q <= fv_q[0] ? open_tally_q + CountW'(1) : open_tally_q - CountW'(1);
          end
          if (chg_lock) begin
            locked_tally_q <= fv_q[0] ? locked_tally_q + CountW'(1)
                                      : locked_tally_q - CountW'(1);
          end
          addr_q       <= '0;
          pass_q       <= 1'b0;
          issue_done_q <= 1'b0;
          rd_vld_q     <= 1'b0;
          // restart the digest only when a flag moved
          if (chg_open || chg_lock) begin
            digest_q <= FNV_BASIS;
          end
        end
        ST_CLR: begin
          if (last_addr) begin
            addr_q       <= '0;
            pass_q       <= 1'b0;
            issue_done_q <= 1'b0;
            rd_vld_q     <= 1'b0;
            digest_q     <= FNV_BASIS;
          end else begin
            addr_q <= addr_q + AW'(1);
          end
        end
        ST_HASH: begin
          // issue reads: open bytes, then locked bytes
          if (!issue_done_q) begin
            if (last_addr) begin
              addr_q <= '0;
              if (pass_q) begin
                issue_done_q <= 1'b1;
              end else begin
                pass_q <= 1'b1;
              end
            end else begin
              addr_q <= addr_q + AW'(1);
            end
          end
          rd_vld_q  <= !issue_done_q;
          rd_pass_q <= pass_q;
          // fold the byte that arrived from the ram
          if (rd_vld_q) begin
            digest_q <= fnv_step(digest_q, hash_byte);
          end
        end
        default: ;
      endcase
    end
  end

  lfd_ram #(
    .DEPTH (TableBytes),
    .AW    (AW)
  ) u_open_ram (
    .clk_i   (clk_i),
    .we_i    (we_open),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (open_rdata)
  );

  lfd_ram #(
    .DEPTH (TableBytes),
    .AW    (AW)
  ) u_lock_ram (
    .clk_i   (clk_i),
    .we_i    (we_lock),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (lock_rdata)
  );

`ifndef SYNTHESIS
  // once ready, the block stays ready
  assert property (@(posedge clk_i) disable iff (!rst_ni) ready_q |=> ready_q)
    else $error("ready flag dropped");

  // tallies never exceed the captured line count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_tally_q <= active_q) && (locked_tally_q <= active_q))
    else $error("tally beyond line count");

  // both tables are written together only by the clearing sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_open && we_lock) |-> (state_q == ST_CLR))
    else $error("double table write outside clear");

  // walk addresses stay inside the active byte range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_HASH || state_q == ST_CLR) && !issue_done_q)
      |-> (16'(addr_q) < 16'(nbytes_q)))
    else $error("walk address out of range");
`endif

endmodule

[sv/line_flag_table_with_digest.sv]
// top level: apb register, op engine and result register
`timescale 1ns / 1ps

// Line flag table with FNV-1a digest. Two bit tables (open, locked) of up to
// LINES_MAX lines are held byte-wide in two single-port-read rams; one op goes
// through at a time. A get or a set that leaves its flag as it was passes the
// engine through the read and response states, a rejected op goes straight to
// the response state. A set that changes a flag rewrites one byte and then
// walks both tables through the ram read port, one byte per cycle through the
// fnv multiply. A clear first zeroes ceil(N/8) bytes of both tables for N
// active lines, one byte a cycle, then does the same walk. line_count is
// written over apb at byte address 0 and is taken by the next clear op. A new
// op is taken while the previous result still waits in the output register.
module line_flag_table_with_digest #(
  parameter int LINES_MAX = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  lfd_pkg::item_t            in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output lfd_pkg::result_t          out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lfd_pkg::ApbAw-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  import lfd_pkg::*;

  logic [CountW-1:0] line_count_q;
  logic              eng_ready, res_valid, res_ready;
  result_t           res;
  logic              out_valid_q;
  result_t           out_data_q;
  logic              reg_sel;

  assign reg_sel = paddr[2] == REG_IDX_LINE_COUNT;
  assign pready  = 1'b1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      line_count_q <= pwdata[CountW-1:0];
    end
  end

  assign prdata = reg_sel ? {{(32-CountW){1'b0}}, line_count_q} : 32'd0;

  lfd_engine #(
    .LINES_MAX (LINES_MAX)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (eng_ready),
    .item_i       (in_data_i),
    .line_count_i (line_count_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  assign in_stall_o = !eng_ready;

  // output register: a new result loads when the slot is empty or drains
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // a stalled transaction on the result side holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // a result with not-ready status always carries a zero digest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == STAT_NOT_READY)
      |-> (out_data_o.state_digest == '0))
    else $error("digest shown while not ready");

  // the engine only starts an op when its result slot logic is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !res_valid)
    else $error("op accepted while result pending in engine");
`endif

endmodule
